// ----- rtl/smr_pkg.sv -----
// Shared types, constants and helpers of the stepper move ramp controller.
package smr_pkg;

  localparam int STEPS_PER_REV_DEF = 200;

  localparam int POS_W      = 8;
  localparam int DL_W       = 9;
  localparam int OFS_W      = 8;
  localparam int CEIL_W     = 7;
  localparam int KNEE_W     = 4;
  localparam int DIV_W      = 12;
  localparam int DVS_W      = 8;
  localparam int CMD_W      = 2;
  localparam int COIL_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_HALL = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_NUM       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_DEN       = 3'd5;

  localparam logic [7:0]        RST_BASE_DELAY = 8'd20;
  localparam logic [7:0]        RST_ACCEL      = 8'd4;
  localparam logic [OFS_W-1:0]  RST_FLOOR      = 8'hF6;
  localparam logic [CEIL_W-1:0] RST_CEILING    = 7'd0;
  localparam logic [KNEE_W-1:0] RST_KNEE_NUM   = 4'd1;
  localparam logic [KNEE_W-1:0] RST_KNEE_DEN   = 4'd2;
  localparam logic [POS_W-1:0]  RST_POSITION   = 8'd1;

  localparam logic [7:0] MAX_COUNT = 8'd255;

  localparam logic [COIL_W-1:0] COIL_PH0 = 6'd48;
  localparam logic [COIL_W-1:0] COIL_PH1 = 6'd6;
  localparam logic [COIL_W-1:0] COIL_PH2 = 6'd40;
  localparam logic [COIL_W-1:0] COIL_PH3 = 6'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_KNEE_LOAD,
    ST_KNEE_DIV,
    ST_STEP,
    ST_MOD_LOAD,
    ST_MOD_DIV,
    ST_RAMP,
    ST_REARM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic move_setup;
    logic hall_set;
    logic tick_count;
    logic knee_load;
    logic knee_store;
    logic step;
    logic mod_load;
    logic ramp;
    logic rearm;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic moving;
    logic same_pos;
    logic step_due;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      2'd0:    pat = COIL_PH0;
      2'd1:    pat = COIL_PH1;
      2'd2:    pat = COIL_PH2;
      default: pat = COIL_PH3;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/smr_div.sv -----
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
module smr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [smr_pkg::DIV_W-1:0]  dividend,
  input  logic [smr_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [smr_pkg::DIV_W-1:0]  quotient,
  output logic [smr_pkg::DVS_W-1:0]  remainder
);
  import smr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so its top bit can go.
      rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/smr_ctrl.sv -----
// Sequencing state machine of the stepper move ramp controller.
module smr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  smr_pkg::dp_status_t status,
  output smr_pkg::ctrl_cmd_t  cmd
);
  import smr_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        case (status.cmd)
          CMD_MOVE: state_nxt = status.same_pos ? ST_FINISH : ST_KNEE_LOAD;
          CMD_TICK: state_nxt = (status.moving && status.step_due) ? ST_STEP : ST_FINISH;
          default:  state_nxt = ST_FINISH;
        endcase
      end
      ST_KNEE_LOAD: state_nxt = ST_KNEE_DIV;
      ST_KNEE_DIV:  if (status.div_done) state_nxt = ST_FINISH;
      ST_STEP:      state_nxt = ST_MOD_LOAD;
      ST_MOD_LOAD:  state_nxt = ST_MOD_DIV;
      ST_MOD_DIV:   if (status.div_done) state_nxt = ST_RAMP;
      ST_RAMP:      state_nxt = ST_REARM;
      ST_REARM:     state_nxt = ST_FINISH;
      ST_FINISH:    if (status.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:      cmd.capture = in_valid;
      ST_DECODE: begin
        case (status.cmd)
          CMD_MOVE: cmd.move_setup = 1'b1;
          CMD_HALL: cmd.hall_set   = 1'b1;
          CMD_TICK: cmd.tick_count = status.moving;
          default:  cmd = '0;
        endcase
      end
      ST_KNEE_LOAD: cmd.knee_load  = 1'b1;
      ST_KNEE_DIV:  cmd.knee_store = status.div_done;
      ST_STEP:      cmd.step       = 1'b1;
      ST_MOD_LOAD:  cmd.mod_load   = 1'b1;
      ST_RAMP:      cmd.ramp       = 1'b1;
      ST_REARM:     cmd.rearm      = 1'b1;
      ST_FINISH:    cmd.out_load   = status.out_free;
      default:      cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ----- rtl/smr_dp.sv -----
// Datapath: motion state, configuration registers, shared divider and result register.
module smr_dp #(
  parameter int STEPS_PER_REV = smr_pkg::STEPS_PER_REV_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  smr_pkg::ctrl_cmd_t              cmd,
  output smr_pkg::dp_status_t             status,
  input  logic [smr_pkg::CMD_W-1:0]       in_command,
  input  logic [smr_pkg::POS_W-1:0]       in_target,
  input  logic                            cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [smr_pkg::COIL_W-1:0]      out_coil_pattern,
  output logic [smr_pkg::POS_W-1:0]       out_position,
  output logic                            out_busy_res,
  output logic                            out_stepped,
  output logic signed [smr_pkg::OFS_W-1:0] out_speed_offset
);
  import smr_pkg::*;

  localparam logic [POS_W:0]   N9       = (POS_W+1)'(STEPS_PER_REV);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(STEPS_PER_REV - 1);

  // Configuration
  logic [7:0]              base_r, base_nxt;
  logic [7:0]              accel_r, accel_nxt;
  logic signed [OFS_W-1:0] floor_r, floor_nxt;
  logic [CEIL_W-1:0]       ceil_r, ceil_nxt;
  logic [KNEE_W-1:0]       num_r, num_nxt;
  logic [KNEE_W-1:0]       den_r, den_nxt;

  // Motion state
  logic [1:0]              phase_r, phase_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [POS_W-1:0]        goal_r, goal_nxt;
  logic                    rev_r, rev_nxt;
  logic                    moving_r, moving_nxt;
  logic [7:0]              msteps_r, msteps_nxt;
  logic signed [OFS_W-1:0] ofs_r, ofs_nxt;
  logic [7:0]              knee_r, knee_nxt;
  logic [DL_W-1:0]         dl_r, dl_nxt;
  logic                    hall_r, hall_nxt;

  // Item payload
  cmd_t                    cmd_in_r;
  logic [POS_W-1:0]        tgt_r;
  logic [POS_W-1:0]        dist_r, dist_nxt;
  logic                    stepped_r, stepped_nxt;

  // Result register
  logic                    out_valid_r, out_valid_nxt;
  logic [COIL_W-1:0]       out_coil_r;
  logic [POS_W-1:0]        out_pos_r;
  logic                    out_busy_r;
  logic                    out_stepped_r;
  logic signed [OFS_W-1:0] out_ofs_r;

  // Combinational helpers
  logic [POS_W-1:0]        tgt_sat;
  logic [POS_W:0]          cur9, tgt9, fwd, rvs;
  logic                    rev_new;
  logic [POS_W-1:0]        dist_new;
  logic                    same_pos;
  logic [DL_W-1:0]         dl_dec;
  logic signed [DL_W:0]    delay_sum;
  logic [DL_W-1:0]         armed;
  logic [POS_W:0]          pos_inc9;
  logic [POS_W-1:0]        pos_step;
  logic [1:0]              phase_step;
  logic [KNEE_W-1:0]       den_eff;
  logic [7:0]              iv_eff;
  logic [DIV_W-1:0]        prod;
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [DVS_W-1:0]        div_divisor;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quo;
  logic [DVS_W-1:0]        div_rem;
  logic [7:0]              knee_sat;
  logic                    before_knee;

  assign tgt_sat = ({1'b0, tgt_r} >= N9) ? LAST_POS : tgt_r;
  assign cur9    = {1'b0, pos_r};
  assign tgt9    = {1'b0, tgt_sat};
  assign fwd     = (tgt9 > cur9) ? (tgt9 - cur9) : (N9 - (cur9 - tgt9));
  assign rvs     = (tgt9 < cur9) ? (cur9 - tgt9) : (N9 - (tgt9 - cur9));
  // An even split between the two ways goes in reverse.
  assign rev_new  = !(fwd < rvs);
  assign dist_new = rev_new ? rvs[POS_W-1:0] : fwd[POS_W-1:0];
  assign same_pos = (tgt_sat == pos_r);

  assign dl_dec = (dl_r == '0) ? '0 : dl_r - 1'b1;

  assign delay_sum = $signed({2'b00, base_r}) + $signed({{2{ofs_r[OFS_W-1]}}, ofs_r});
  assign armed     = (delay_sum < $signed((DL_W+1)'(1))) ? DL_W'(1) : delay_sum[DL_W-1:0];

  assign pos_inc9   = cur9 + 1'b1;
  assign pos_step   = rev_r ? ((pos_r == '0) ? LAST_POS : pos_r - 1'b1)
                            : ((pos_inc9 >= N9) ? '0 : pos_inc9[POS_W-1:0]);
  assign phase_step = rev_r ? phase_r - 1'b1 : phase_r + 1'b1;

  assign den_eff = (den_r == '0) ? KNEE_W'(1) : den_r;
  assign iv_eff  = (accel_r == '0) ? 8'd1 : accel_r;
  assign prod    = {{(DIV_W-KNEE_W){1'b0}}, num_r} * {{(DIV_W-POS_W){1'b0}}, dist_r};

  assign div_start    = cmd.knee_load | cmd.mod_load;
  assign div_dividend = cmd.knee_load ? prod : {{(DIV_W-8){1'b0}}, msteps_r};
  assign div_divisor  = cmd.knee_load ? {{(DVS_W-KNEE_W){1'b0}}, den_eff} : iv_eff;

  smr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign knee_sat    = (div_quo > {{(DIV_W-8){1'b0}}, MAX_COUNT}) ? MAX_COUNT : div_quo[7:0];
  assign before_knee = (msteps_r < knee_r);

  always_comb begin
    base_nxt    = base_r;
    accel_nxt   = accel_r;
    floor_nxt   = floor_r;
    ceil_nxt    = ceil_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    goal_nxt    = goal_r;
    rev_nxt     = rev_r;
    moving_nxt  = moving_r;
    msteps_nxt  = msteps_r;
    ofs_nxt     = ofs_r;
    knee_nxt    = knee_r;
    dl_nxt      = dl_r;
    hall_nxt    = hall_r;
    dist_nxt    = dist_r;
    stepped_nxt = stepped_r;

    if (cmd.capture) stepped_nxt = 1'b0;

    if (cmd.move_setup) begin
      msteps_nxt = '0;
      ofs_nxt    = '0;
      goal_nxt   = tgt_sat;
      if (same_pos) begin
        moving_nxt = 1'b0;
      end else begin
        rev_nxt  = rev_new;
        dist_nxt = dist_new;
      end
    end

    if (cmd.hall_set) hall_nxt = 1'b1;

    if (cmd.tick_count) dl_nxt = dl_dec;

    if (cmd.knee_store) begin
      knee_nxt   = knee_sat;
      moving_nxt = 1'b1;
      dl_nxt     = armed;
    end

    if (cmd.step) begin
      phase_nxt   = phase_step;
      stepped_nxt = 1'b1;
      if (msteps_r != MAX_COUNT) msteps_nxt = msteps_r + 1'b1;
      // A pending hall event marks the home position.
      if (hall_r) begin
        pos_nxt  = '0;
        hall_nxt = 1'b0;
      end else begin
        pos_nxt = pos_step;
      end
    end

    if (cmd.ramp) begin
      if ((div_rem == '0) && before_knee && (ofs_r > floor_r)) ofs_nxt = ofs_r - 1'b1;
      if (!before_knee && (ofs_r < $signed({1'b0, ceil_r}))) ofs_nxt = ofs_r + 1'b1;
      moving_nxt = (pos_r != goal_r);
    end

    if (cmd.rearm && moving_r) dl_nxt = armed;

    if (cfg_we) begin
      case (cfg_index)
        REG_BASE_DELAY:     base_nxt  = cfg_data;
        REG_ACCEL_INTERVAL: accel_nxt = cfg_data;
        REG_OFFSET_FLOOR:   floor_nxt = $signed(cfg_data);
        REG_OFFSET_CEILING: ceil_nxt  = cfg_data[CEIL_W-1:0];
        REG_KNEE_NUM:       num_nxt   = cfg_data[KNEE_W-1:0];
        REG_KNEE_DEN:       den_nxt   = cfg_data[KNEE_W-1:0];
        default:            base_nxt  = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= RST_BASE_DELAY;
      accel_r  <= RST_ACCEL;
      floor_r  <= RST_FLOOR;
      ceil_r   <= RST_CEILING;
      num_r    <= RST_KNEE_NUM;
      den_r    <= RST_KNEE_DEN;
      phase_r  <= '0;
      pos_r    <= RST_POSITION;
      goal_r   <= '0;
      rev_r    <= 1'b0;
      moving_r <= 1'b0;
      msteps_r <= '0;
      ofs_r    <= '0;
      knee_r   <= '0;
      dl_r     <= '0;
      hall_r   <= 1'b0;
    end else begin
      base_r   <= base_nxt;
      accel_r  <= accel_nxt;
      floor_r  <= floor_nxt;
      ceil_r   <= ceil_nxt;
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      goal_r   <= goal_nxt;
      rev_r    <= rev_nxt;
      moving_r <= moving_nxt;
      msteps_r <= msteps_nxt;
      ofs_r    <= ofs_nxt;
      knee_r   <= knee_nxt;
      dl_r     <= dl_nxt;
      hall_r   <= hall_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_in_r <= cmd_t'(in_command);
      tgt_r    <= in_target;
    end
    dist_r    <= dist_nxt;
    stepped_r <= stepped_nxt;
    if (cmd.out_load) begin
      out_coil_r    <= coil_of(phase_r);
      out_pos_r     <= pos_r;
      out_busy_r    <= moving_r;
      out_stepped_r <= stepped_r;
      out_ofs_r     <= ofs_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.cmd      = cmd_in_r;
  assign status.moving   = moving_r;
  assign status.same_pos = same_pos;
  assign status.step_due = (dl_dec == '0);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = out_coil_r;
  assign out_position     = out_pos_r;
  assign out_busy_res     = out_busy_r;
  assign out_stepped      = out_stepped_r;
  assign out_speed_offset = out_ofs_r;

endmodule

// ----- rtl/stepper_move_ramp_controller_top.sv -----
// Stepper move ramp controller: top level joining the sequencer and the datapath.
//
// Input channel (in_valid / in_stall, fields in_command and in_target) takes one
// command per beat: a millisecond tick, a move to a target position, or a hall
// event. Every accepted beat yields exactly one result beat on the output
// channel (out_valid / out_stall) carrying coil pattern, position, busy flag,
// step flag and the current speed offset.
// Sequence per beat: a tick that takes no step, a hall event, an unused code and a
// move to the current position go from decode straight to the result stage.
// A move that starts motion and a tick that takes a step first pass through the
// shared bit-serial divider (knee fraction for a move, interval remainder for a
// step) before the result is loaded.
// One beat is worked on at a time; in_stall is high until it is finished.
// The result sits in an output register, so the next beat is accepted while
// the receiver stalls; a second result waits until that register is taken.
// Configuration writes (cfg_valid / cfg_ready, always ready) land directly in the registers.
// Synchronous reset (rst_n low) restores the default configuration, parks the
// motor at position 1, phase 0, idle, and empties the output register.
module stepper_move_ramp_controller_top #(
  parameter int STEPS_PER_REV = smr_pkg::STEPS_PER_REV_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [smr_pkg::CMD_W-1:0]        in_command,
  input  logic [smr_pkg::POS_W-1:0]        in_target,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [smr_pkg::COIL_W-1:0]       out_coil_pattern,
  output logic [smr_pkg::POS_W-1:0]        out_position,
  output logic                             out_busy_res,
  output logic                             out_stepped,
  output logic signed [smr_pkg::OFS_W-1:0] out_speed_offset,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import smr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  smr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  smr_dp #(
    .STEPS_PER_REV (STEPS_PER_REV)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_command       (in_command),
    .in_target        (in_target),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_coil_pattern (out_coil_pattern),
    .out_position     (out_position),
    .out_busy_res     (out_busy_res),
    .out_stepped      (out_stepped),
    .out_speed_offset (out_speed_offset)
  );

endmodule

// ----- rtl/smr_checker.sv -----
// Port-level checker of the stepper move ramp controller and its bind.
module smr_checker #(
  parameter int STEPS_PER_REV = smr_pkg::STEPS_PER_REV_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [smr_pkg::COIL_W-1:0]       out_coil_pattern,
  input logic [smr_pkg::POS_W-1:0]        out_position,
  input logic                             out_busy_res,
  input logic                             out_stepped,
  input logic signed [smr_pkg::OFS_W-1:0] out_speed_offset
);
  import smr_pkg::*;

  // Reset leaves the result register empty and the input side open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

  // Only one beat is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after a beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_coil_pattern)
      && $stable(out_position) && $stable(out_busy_res) && $stable(out_stepped)
      && $stable(out_speed_offset)))
    else $error("stalled result beat changed");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position < POS_W'(STEPS_PER_REV)))
    else $error("position off the ring");

  a_coil_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coil_pattern == COIL_PH0 || out_coil_pattern == COIL_PH1
      || out_coil_pattern == COIL_PH2 || out_coil_pattern == COIL_PH3))
    else $error("coil pattern not a phase table entry");

endmodule

bind stepper_move_ramp_controller_top smr_checker #(
  .STEPS_PER_REV (STEPS_PER_REV)
) u_smr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_coil_pattern (out_coil_pattern),
  .out_position     (out_position),
  .out_busy_res     (out_busy_res),
  .out_stepped      (out_stepped),
  .out_speed_offset (out_speed_offset)
);

// ----- tb/stepper_move_ramp_controller_top_tb.sv -----
// Self-checking testbench for the stepper move ramp controller, with its own model of the ramp.
`timescale 1ns / 100ps

module stepper_move_ramp_controller_top_tb;
  import smr_pkg::*;

  localparam int N_POS = STEPS_PER_REV_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] tgt;
  } motor_cmd_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil;
    logic [POS_W-1:0]  pos;
    logic              busy;
    logic              stepped;
    logic [OFS_W-1:0]  ofs;
  } motor_report_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [CMD_W-1:0]               in_command = '0;
  logic [POS_W-1:0]               in_target = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [COIL_W-1:0]              out_coil_pattern;
  logic [POS_W-1:0]               out_position;
  logic                           out_busy_res;
  logic                           out_stepped;
  logic signed [OFS_W-1:0]        out_speed_offset;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_data = '0;

  // Model of the motor: configuration and state.
  int cf_base = RST_BASE_DELAY;
  int cf_interval = RST_ACCEL;
  int cf_floor = int'($signed(RST_FLOOR));
  int cf_ceiling = RST_CEILING;
  int cf_num = RST_KNEE_NUM;
  int cf_den = RST_KNEE_DEN;

  logic [1:0] phase_idx = 2'd0;
  int ring_pos = RST_POSITION;
  int goal_pos = 0;
  bit rev_dir = 1'b0;
  bit in_motion = 1'b0;
  int steps_done = 0;
  int ofs_now = 0;
  int knee_cnt = 0;
  int dly_left = 0;
  bit hall_flag = 1'b0;

  motor_cmd_t    pending_cmds[$];
  motor_report_t reports_due[$];
  int cmds_pushed = 0;
  int cmds_taken = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit gaps_in_on = 1'b1;
  bit stalls_out_on = 1'b1;

  stepper_move_ramp_controller_top #(.STEPS_PER_REV(N_POS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_target       (in_target),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coil_pattern(out_coil_pattern),
    .out_position    (out_position),
    .out_busy_res    (out_busy_res),
    .out_stepped     (out_stepped),
    .out_speed_offset(out_speed_offset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial forever #4 clk = ~clk;

  function automatic int rearm_delay();
    int d;
    d = cf_base + ofs_now;
    return (d < 1) ? 1 : d;
  endfunction

  // Advances the model by one command and returns the report it should produce.
  function automatic motor_report_t predict_motor(input logic [CMD_W-1:0] cmd,
                                                  input logic [POS_W-1:0] tgt);
    motor_report_t rep;
    int t, fwd, bwd, span_len, den, knee, iv;
    bit stepped;
    stepped = 1'b0;
    if (cmd == CMD_MOVE) begin
      t = (tgt >= N_POS) ? N_POS - 1 : int'(tgt);
      steps_done = 0;
      ofs_now = 0;
      goal_pos = t;
      if (ring_pos == t) begin
        in_motion = 1'b0;
      end else begin
        fwd = (t > ring_pos) ? t - ring_pos : N_POS - (ring_pos - t);
        bwd = (t < ring_pos) ? ring_pos - t : N_POS - (t - ring_pos);
        // A tie between the two ways goes in reverse.
        rev_dir = !(fwd < bwd);
        span_len = rev_dir ? bwd : fwd;
        den = (cf_den == 0) ? 1 : cf_den;
        knee = cf_num * span_len / den;
        knee_cnt = (knee > 255) ? 255 : knee;
        in_motion = 1'b1;
        dly_left = rearm_delay();
      end
    end else if (cmd == CMD_HALL) begin
      hall_flag = 1'b1;
    end else if (cmd == CMD_TICK && in_motion) begin
      if (dly_left > 0) dly_left--;
      if (dly_left == 0) begin
        stepped = 1'b1;
        if (!rev_dir) begin
          phase_idx = phase_idx + 2'd1;
          ring_pos = (ring_pos + 1 >= N_POS) ? 0 : ring_pos + 1;
        end else begin
          phase_idx = phase_idx - 2'd1;
          ring_pos = (ring_pos == 0) ? N_POS - 1 : ring_pos - 1;
        end
        if (steps_done < 255) steps_done++;
        if (hall_flag) begin
          ring_pos = 0;
          hall_flag = 1'b0;
        end
        iv = (cf_interval == 0) ? 1 : cf_interval;
        if ((steps_done % iv) == 0 && steps_done < knee_cnt && ofs_now > cf_floor) ofs_now--;
        if (steps_done >= knee_cnt && ofs_now < cf_ceiling) ofs_now++;
        if (ring_pos == goal_pos) in_motion = 1'b0;
        else dly_left = rearm_delay();
      end
    end
    case (phase_idx)
      2'd0:    rep.coil = COIL_PH0;
      2'd1:    rep.coil = COIL_PH1;
      2'd2:    rep.coil = COIL_PH2;
      default: rep.coil = COIL_PH3;
    endcase
    rep.pos = ring_pos[POS_W-1:0];
    rep.busy = in_motion;
    rep.stepped = stepped;
    rep.ofs = ofs_now[OFS_W-1:0];
    return rep;
  endfunction

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int pick_pause(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: presents queued commands, holding each beat while stalled.
  always @(posedge clk) begin : drive_proc
    motor_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reports_due.push_back(predict_motor(in_command, in_target));
        cmds_taken++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        nxt = pending_cmds.pop_front();
        in_command <= nxt.cmd;
        in_target <= nxt.tgt;
        in_valid <= 1'b1;
        gap_left = pick_pause(gaps_in_on);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted result beat and drives the result stall.
  always @(posedge clk) begin : watch_proc
    motor_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $display("%0t: result beat with none expected, position %0d", $time, out_position);
        fail_cnt++;
      end else begin
        want = reports_due.pop_front();
        check_field("coil_pattern", want.coil, out_coil_pattern);
        check_field("position", want.pos, out_position);
        check_field("busy_res", want.busy, out_busy_res);
        check_field("stepped", want.stepped, out_stepped);
        check_field("speed_offset", $signed(want.ofs), out_speed_offset);
      end
    end
    if (stall_left == 0) stall_left = pick_pause(stalls_out_on);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int tgt);
    motor_cmd_t c;
    c.cmd = cmd;
    c.tgt = tgt[POS_W-1:0];
    pending_cmds.push_back(c);
    cmds_pushed++;
  endtask

  task automatic sync_taken();
    do @(posedge clk); while (cmds_taken != cmds_pushed);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (cmds_taken != cmds_pushed || reports_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BASE_DELAY:     cf_base = val;
      REG_ACCEL_INTERVAL: cf_interval = val;
      REG_OFFSET_FLOOR:   cf_floor = $signed(val);
      REG_OFFSET_CEILING: cf_ceiling = val[CEIL_W-1:0];
      REG_KNEE_NUM:       cf_num = val[KNEE_W-1:0];
      REG_KNEE_DEN:       cf_den = val[KNEE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ramp(input int base, input int iv, input int flr, input int ceil_v,
                          input int num, input int den);
    wait_idle();
    write_reg(REG_BASE_DELAY, 8'(base));
    write_reg(REG_ACCEL_INTERVAL, 8'(iv));
    write_reg(REG_OFFSET_FLOOR, 8'(flr));
    write_reg(REG_OFFSET_CEILING, 8'(ceil_v));
    write_reg(REG_KNEE_NUM, 8'(num));
    write_reg(REG_KNEE_DEN, 8'(den));
  endtask

  // Issues moves, feeding mostly-tick batches until a move ends or hits the tick cap or budget.
  task automatic run_moves(input int budget, input int span, input int hall_pct,
                           input int tick_cap, input bit long_run);
    int used, tgt, delta, r, batch, ticks;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(0, 9);
      if (long_run) begin
        tgt = (ring_pos + 99) % N_POS;
      end else if (r < 6) begin
        delta = $urandom_range(1, span);
        tgt = $urandom_range(0, 1) ? (ring_pos + delta) % N_POS
                                   : (ring_pos + N_POS - delta) % N_POS;
      end else if (r < 9) begin
        tgt = $urandom_range(0, 255);
      end else begin
        tgt = ring_pos;
      end
      push_cmd(CMD_MOVE, tgt);
      used++;
      ticks = 0;
      sync_taken();
      while (in_motion && used < budget && ticks < tick_cap) begin
        batch = $urandom_range(4, 16);
        repeat (batch) begin
          r = $urandom_range(0, 99);
          if (r < hall_pct) push_cmd(CMD_HALL, $urandom_range(0, 255));
          else if (r < hall_pct + 2) push_cmd(CMD_UNUSED, $urandom_range(0, 255));
          else if (r < hall_pct + 3) push_cmd(CMD_MOVE, $urandom_range(0, 255));
          else push_cmd(CMD_TICK, $urandom_range(0, 255));
        end
        used += batch;
        ticks += batch;
        sync_taken();
      end
      // A little noise while the motor rests.
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(0, 2);
          if (r == 0) push_cmd(CMD_TICK, $urandom_range(0, 255));
          else if (r == 1) push_cmd(CMD_HALL, $urandom_range(0, 255));
          else push_cmd(CMD_UNUSED, $urandom_range(0, 255));
          used++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int p;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats, with a one-millisecond step delay so that steps come quickly.
    write_reg(REG_BASE_DELAY, 8'd1);
    push_cmd(CMD_UNUSED, 255);
    push_cmd(CMD_TICK, 0);
    push_cmd(CMD_HALL, 0);
    push_cmd(CMD_MOVE, 1);
    push_cmd(CMD_MOVE, 255);
    push_cmd(CMD_UNUSED, 0);
    push_cmd(CMD_MOVE, 2);
    repeat (3) push_cmd(CMD_TICK, 0);
    push_cmd(CMD_HALL, 128);
    push_cmd(CMD_MOVE, 0);
    repeat (2) push_cmd(CMD_TICK, 170);
    push_cmd(CMD_MOVE, 200);
    repeat (3) push_cmd(CMD_TICK, 85);
    push_cmd(CMD_MOVE, 199);
    push_cmd(CMD_MOVE, 198);
    push_cmd(CMD_TICK, 0);
    push_cmd(CMD_TICK, 0);

    // Fastest extreme: zero interval and zero denominator, a floor of -127, saturating knee.
    set_ramp(1, 0, -127, 0, 15, 0);
    run_moves(250, 30, 2, 300, 1'b0);

    // Slowest extreme: longest base delay, decelerating straight up to the top ceiling.
    set_ramp(255, 255, 0, 127, 0, 15);
    run_moves(280, 1, 1, 300, 1'b0);

    // Long moves kept going by hall events, so that the step count saturates.
    wait_idle();
    gaps_in_on = 1'b0;
    stalls_out_on = 1'b0;
    set_ramp(1, 1, 0, 0, 15, 1);
    run_moves(350, 1, 3, 600, 1'b1);

    for (p = 0; p < 4; p++) begin
      wait_idle();
      gaps_in_on = ($urandom_range(0, 3) != 0);
      stalls_out_on = ($urandom_range(0, 3) != 0);
      set_ramp($urandom_range(1, 4), $urandom_range(0, 8), 0 - int'($urandom_range(0, 12)),
               $urandom_range(0, 6), $urandom_range(0, 15), $urandom_range(0, 15));
      run_moves(200, $urandom_range(1, 20), $urandom_range(0, 3), 300, 1'b0);
    end

    wait_idle();
    gaps_in_on = 1'b1;
    stalls_out_on = 1'b1;
    set_ramp(1, 2, -5, 127, 8, 15);
    run_moves(270, 12, 1, 300, 1'b0);

    wait_idle();
    repeat (64) @(posedge clk);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/smr_pkg.sv
rtl/smr_div.sv
rtl/smr_ctrl.sv
rtl/smr_dp.sv
rtl/stepper_move_ramp_controller_top.sv
rtl/smr_checker.sv
tb/stepper_move_ramp_controller_top_tb.sv
